[rtl/sgd_pkg.sv]
// ----------------------------------------------------------------------------
// sgd_pkg: shared types and constants of the swipe gesture detector
// Event command codes, configuration register indexes, reset values and the
// fixed field widths used by the interfaces and the detector core.
// ----------------------------------------------------------------------------
`default_nettype none

package sgd_pkg;

    // touch event command codes
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_PRESS   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_command;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST2  = 2'd1;

    // fixed field widths
    localparam int LIMIT_W  = 16;
    localparam int MIN_D2_W = 33;
    localparam int CFG_W    = 33;
    localparam int OUT_W    = 24;

    // register reset values
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET   = 16'd200;
    localparam logic [MIN_D2_W-1:0] MIN_D2_RESET  = 33'd76800;

    // saturation bounds of a result field (magnitudes)
    localparam logic [OUT_W-1:0] OUT_POS_MAX = 24'h7FFFFF;
    localparam logic [OUT_W-1:0] OUT_NEG_MIN = 24'h800000;

endpackage

`default_nettype wire

[rtl/sgd_if.sv]
// ----------------------------------------------------------------------------
// sgd_if: valid/ready channels of the swipe gesture detector
// Touch event channel, swipe result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// touch event channel
interface sgd_evt_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic signed [COORD_WIDTH-1:0] x_pos;
    logic signed [COORD_WIDTH-1:0] y_pos;

    modport source (output valid, command, x_pos, y_pos, input ready);
    modport sink   (input valid, command, x_pos, y_pos, output ready);
endinterface

// swipe result channel
interface sgd_swipe_if;
    import sgd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] swipe_dx;
    logic signed [OUT_W-1:0] swipe_dy;

    modport source (output valid, swipe_dx, swipe_dy, input ready);
    modport sink   (input valid, swipe_dx, swipe_dy, output ready);
endinterface

// configuration write channel
interface sgd_cfg_if;
    import sgd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/swipe_gesture_detector_top.sv]
// ----------------------------------------------------------------------------
// swipe_gesture_detector_top: touch swipe detector with velocity scaling
// i_evt carries touch requests (tick, press, release with a Q12.4 position).
// i_cfg writes the time limit (index 0) and the minimum squared distance
// (index 1); it is always ready. It must be written only while the block
// is idle; the block itself does not enforce this. o_swipe carries the
// scaled displacement of a detected swipe. i_evt stays ready after ticks,
// presses and ignored releases. A release that ends a gesture within the
// time limit runs through one shared multiplier (two squares, a compare,
// two products) and then a restoring divider that retires one quotient bit
// per cycle for both axes. i_evt is not ready until the block is idle again;
// a release that misses the distance minimum frees i_evt after the two
// squares and the compare. The result sits in an output register, so new
// events are taken while it waits; a second swipe waits in its final step
// until o_swipe is free.
// Reset (synchronous, active low) clears the gesture state, drops any pending
// result and loads the registers with 200 ticks and 76800 (300 px^2).
// ----------------------------------------------------------------------------
`default_nettype none

module swipe_gesture_detector_top #(
    parameter int COORD_WIDTH      = 16,
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    sgd_evt_if.sink   i_evt,
    sgd_cfg_if.sink   i_cfg,
    sgd_swipe_if.source o_swipe
);
    import sgd_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int TW   = TICK_COUNT_WIDTH;
    localparam int DW   = CW + 1;                       // displacement magnitude
    localparam int MW   = (DW > LIMIT_W) ? DW : LIMIT_W; // multiplier operand
    localparam int PW   = 2 * MW;                       // product
    localparam int AW   = PW + 2;                       // squared distance sum
    localparam int NW   = DW + LIMIT_W;                 // dividend / quotient
    localparam int CNTW = $clog2(NW + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SQX  = 8'b0000_0010,
        S_SQY  = 8'b0000_0100,
        S_CMP  = 8'b0000_1000,
        S_MULX = 8'b0001_0000,
        S_MULY = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic                r_pressed, n_pressed;
    logic [TW-1:0]       r_elapsed, n_elapsed;
    logic [CW-1:0]       r_start_x, n_start_x;
    logic [CW-1:0]       r_start_y, n_start_y;
    logic [LIMIT_W-1:0]  r_limit, n_limit;
    logic [MIN_D2_W-1:0] r_min_d2, n_min_d2;
    logic [DW-1:0]       r_mag_x, n_mag_x;
    logic [DW-1:0]       r_mag_y, n_mag_y;
    logic                r_neg_x, n_neg_x;
    logic                r_neg_y, n_neg_y;
    logic [LIMIT_W-1:0]  r_div, n_div;
    logic [AW-1:0]       r_acc, n_acc;
    logic [NW-1:0]       r_num_x, n_num_x;
    logic [NW-1:0]       r_num_y, n_num_y;
    logic [LIMIT_W-1:0]  r_rem_x, n_rem_x;
    logic [LIMIT_W-1:0]  r_rem_y, n_rem_y;
    logic [CNTW-1:0]     r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic [OUT_W-1:0]    r_out_dx, n_out_dx;
    logic [OUT_W-1:0]    r_out_dy, n_out_dy;

    logic                evt_req;
    logic                cfg_req;
    logic signed [DW-1:0] diff_x, diff_y;
    logic [TW+LIMIT_W-1:0] elapsed_ext;
    logic [TW+LIMIT_W-1:0] limit_ext;
    logic [MW-1:0]       op_a, op_b;
    logic [PW-1:0]       prod;
    logic [LIMIT_W:0]    trial_x, trial_y;
    logic                fit_x, fit_y;
    logic [OUT_W-1:0]    sat_dx, sat_dy;

    assign evt_req = i_evt.valid && i_evt.ready;
    assign cfg_req = i_cfg.valid && i_cfg.ready;

    assign i_evt.ready    = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_swipe.valid    = r_out_valid;
    assign o_swipe.swipe_dx = r_out_dx;
    assign o_swipe.swipe_dy = r_out_dy;

    // displacement from the start point and elapsed-vs-limit compare
    assign diff_x = $signed({i_evt.x_pos[CW-1], i_evt.x_pos}) -
                    $signed({r_start_x[CW-1], r_start_x});
    assign diff_y = $signed({i_evt.y_pos[CW-1], i_evt.y_pos}) -
                    $signed({r_start_y[CW-1], r_start_y});
    assign elapsed_ext = {{LIMIT_W{1'b0}}, r_elapsed};
    assign limit_ext   = {{TW{1'b0}}, r_limit};

    // shared multiplier operand select
    always_comb begin
        op_a = MW'(r_mag_x);
        op_b = MW'(r_mag_x);
        case (r_state)
            S_SQY: begin
                op_a = MW'(r_mag_y);
                op_b = MW'(r_mag_y);
            end
            S_MULX: begin
                op_a = MW'(r_mag_x);
                op_b = MW'(r_limit);
            end
            S_MULY: begin
                op_a = MW'(r_mag_y);
                op_b = MW'(r_limit);
            end
            default: begin
                op_a = MW'(r_mag_x);
                op_b = MW'(r_mag_x);
            end
        endcase
    end

    assign prod = op_a * op_b;

    // restoring divide step, one lane per axis
    assign trial_x = {r_rem_x, r_num_x[NW-1]};
    assign trial_y = {r_rem_y, r_num_y[NW-1]};
    assign fit_x   = (trial_x >= {1'b0, r_div});
    assign fit_y   = (trial_y >= {1'b0, r_div});

    // saturate quotient magnitudes and apply signs
    always_comb begin
        if (r_neg_x) begin
            sat_dx = (r_num_x >= NW'(OUT_NEG_MIN)) ? OUT_NEG_MIN
                                                   : (~r_num_x[OUT_W-1:0] + 1'b1);
        end else begin
            sat_dx = (r_num_x > NW'(OUT_POS_MAX)) ? OUT_POS_MAX : r_num_x[OUT_W-1:0];
        end
        if (r_neg_y) begin
            sat_dy = (r_num_y >= NW'(OUT_NEG_MIN)) ? OUT_NEG_MIN
                                                   : (~r_num_y[OUT_W-1:0] + 1'b1);
        end else begin
            sat_dy = (r_num_y > NW'(OUT_POS_MAX)) ? OUT_POS_MAX : r_num_y[OUT_W-1:0];
        end
    end

    // sequencer and next-state logic
    always_comb begin
        n_state     = r_state;
        n_pressed   = r_pressed;
        n_elapsed   = r_elapsed;
        n_start_x   = r_start_x;
        n_start_y   = r_start_y;
        n_limit     = r_limit;
        n_min_d2    = r_min_d2;
        n_mag_x     = r_mag_x;
        n_mag_y     = r_mag_y;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        n_div       = r_div;
        n_acc       = r_acc;
        n_num_x     = r_num_x;
        n_num_y     = r_num_y;
        n_rem_x     = r_rem_x;
        n_rem_y     = r_rem_y;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_dx    = r_out_dx;
        n_out_dy    = r_out_dy;

        // result taken by the receiver
        if (r_out_valid && o_swipe.ready) begin
            n_out_valid = 1'b0;
        end

        // register writes
        if (cfg_req) begin
            if (i_cfg.index == REG_TIME_LIMIT) begin
                n_limit = i_cfg.data[LIMIT_W-1:0];
            end else if (i_cfg.index == REG_MIN_DIST2) begin
                n_min_d2 = i_cfg.data[MIN_D2_W-1:0];
            end
        end

        case (r_state)
            S_IDLE: begin
                if (evt_req) begin
                    case (i_evt.command)
                        CMD_TICK: begin
                            if (r_pressed && (r_elapsed != {TW{1'b1}})) begin
                                n_elapsed = r_elapsed + 1'b1;
                            end
                        end
                        CMD_PRESS: begin
                            if (!r_pressed) begin
                                n_pressed = 1'b1;
                                n_elapsed = '0;
                                n_start_x = i_evt.x_pos;
                                n_start_y = i_evt.y_pos;
                            end
                        end
                        CMD_RELEASE: begin
                            if (r_pressed) begin
                                n_pressed = 1'b0;
                                if (elapsed_ext < limit_ext) begin
                                    n_neg_x = diff_x[DW-1];
                                    n_neg_y = diff_y[DW-1];
                                    n_mag_x = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
                                    n_mag_y = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
                                    // elapsed is below a 16-bit limit here
                                    n_div   = (r_elapsed == '0) ? LIMIT_W'(1)
                                                                : elapsed_ext[LIMIT_W-1:0];
                                    n_state = S_SQX;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SQX: begin
                n_acc   = AW'(prod);
                n_state = S_SQY;
            end
            S_SQY: begin
                n_acc   = r_acc + AW'(prod);
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = (r_acc >= AW'(r_min_d2)) ? S_MULX : S_IDLE;
            end
            S_MULX: begin
                n_num_x = prod[NW-1:0];
                n_state = S_MULY;
            end
            S_MULY: begin
                n_num_y = prod[NW-1:0];
                n_rem_x = '0;
                n_rem_y = '0;
                n_cnt   = CNTW'(NW);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem_x = fit_x ? LIMIT_W'(trial_x - {1'b0, r_div}) : trial_x[LIMIT_W-1:0];
                n_rem_y = fit_y ? LIMIT_W'(trial_y - {1'b0, r_div}) : trial_y[LIMIT_W-1:0];
                n_num_x = {r_num_x[NW-2:0], fit_x};
                n_num_y = {r_num_y[NW-2:0], fit_y};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_swipe.ready) begin
                    n_out_valid = 1'b1;
                    n_out_dx    = sat_dx;
                    n_out_dy    = sat_dy;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pressed   <= 1'b0;
            r_elapsed   <= '0;
            r_limit     <= LIMIT_RESET;
            r_min_d2    <= MIN_D2_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pressed   <= n_pressed;
            r_elapsed   <= n_elapsed;
            r_limit     <= n_limit;
            r_min_d2    <= n_min_d2;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_start_x <= n_start_x;
        r_start_y <= n_start_y;
        r_mag_x   <= n_mag_x;
        r_mag_y   <= n_mag_y;
        r_neg_x   <= n_neg_x;
        r_neg_y   <= n_neg_y;
        r_div     <= n_div;
        r_acc     <= n_acc;
        r_num_x   <= n_num_x;
        r_num_y   <= n_num_y;
        r_rem_x   <= n_rem_x;
        r_rem_y   <= n_rem_y;
        r_cnt     <= n_cnt;
        r_out_dx  <= n_out_dx;
        r_out_dy  <= n_out_dy;
    end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench of swipe_gesture_detector_top
// Drives touch requests and register writes over the valid/ready channels,
// tracks the gesture state in a behavioral predictor, and compares every
// swipe result field by field with the oldest predicted one. Directed cases
// cover ignored requests, register extremes, output saturation and holds
// right at the time limit, and one long stall of the result side; random
// gestures follow under several register settings, with random gaps on both
// sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import sgd_pkg::*;

    localparam int COORD_W         = 16;
    localparam int TICK_W          = 16;
    localparam int DRAIN_CYCLES    = 60;    // longer than a release takes to reach its result
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_REQUESTS  = 170;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        logic signed [OUT_W-1:0] dx;
        logic signed [OUT_W-1:0] dy;
    } t_swipe;

    logic i_clk;
    logic i_rst_n;

    sgd_evt_if #(.COORD_WIDTH(COORD_W)) evt_bus ();
    sgd_cfg_if   cfg_bus ();
    sgd_swipe_if swipe_bus ();

    swipe_gesture_detector_top #(
        .COORD_WIDTH      (COORD_W),
        .TICK_COUNT_WIDTH (TICK_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_bus),
        .i_cfg   (cfg_bus),
        .o_swipe (swipe_bus)
    );

    // predictor state and register copies
    logic                      touch_down;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [TICK_W-1:0]         held_ticks;
    logic [LIMIT_W-1:0]        time_limit;
    logic [MIN_D2_W-1:0]       min_dist2;

    t_swipe pending_swipes[$];
    int     mismatches   = 0;
    int     swipes_taken = 0;
    int     taken_seen   = 0;
    int     sink_wait    = 0;
    int     idle_cycles  = 0;
    logic   send_gaps    = 1'b1;
    logic   sink_gaps    = 1'b1;
    logic   sink_hold    = 1'b0;
    event   stall_sink;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // scaled displacement of one axis, truncated toward zero and saturated
    function automatic logic signed [OUT_W-1:0] scale_axis(longint delta, longint span);
        longint q;
        q = (delta * longint'(time_limit)) / span;
        if (q > longint'(OUT_POS_MAX))
            return OUT_POS_MAX;
        if (q < longint'($signed(OUT_NEG_MIN)))
            return OUT_NEG_MIN;
        return q[OUT_W-1:0];
    endfunction

    // gesture tracking for one accepted request
    function automatic void track_gesture(t_command cmd, logic signed [COORD_W-1:0] x,
                                          logic signed [COORD_W-1:0] y);
        longint dx;
        longint dy;
        longint d2;
        longint span;
        t_swipe s;
        case (cmd)
            CMD_TICK: begin
                if (touch_down && held_ticks != {TICK_W{1'b1}})
                    held_ticks = held_ticks + 1'b1;
            end
            CMD_PRESS: begin
                if (!touch_down) begin
                    touch_down = 1'b1;
                    held_ticks = '0;
                    origin_x   = x;
                    origin_y   = y;
                end
            end
            CMD_RELEASE: begin
                if (touch_down) begin
                    touch_down = 1'b0;
                    if (held_ticks < time_limit) begin
                        dx = longint'(x) - longint'(origin_x);
                        dy = longint'(y) - longint'(origin_y);
                        d2 = dx * dx + dy * dy;
                        if (d2 >= longint'(min_dist2)) begin
                            span = (held_ticks == '0) ? 64'sd1 : longint'(held_ticks);
                            s.dx = scale_axis(dx, span);
                            s.dy = scale_axis(dy, span);
                            pending_swipes.push_back(s);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic flag_failure(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $time, what);
    endtask

    // send one touch request, after a random gap when enabled
    task automatic send_event(t_command cmd, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y);
        int gap;
        gap = send_gaps ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            evt_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        evt_bus.valid   <= 1'b1;
        evt_bus.command <= cmd;
        evt_bus.x_pos   <= x;
        evt_bus.y_pos   <= y;
        do @(posedge i_clk); while (!evt_bus.ready);
        track_gesture(cmd, x, y);
    endtask

    // stop sending and wait until every predicted swipe has come out
    task automatic drain_swipes();
        @(negedge i_clk);
        evt_bus.valid <= 1'b0;
        while (pending_swipes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (idx == REG_TIME_LIMIT)
            time_limit = value[LIMIT_W-1:0];
        else if (idx == REG_MIN_DIST2)
            min_dist2 = value[MIN_D2_W-1:0];
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_registers(logic [LIMIT_W-1:0] lim, logic [MIN_D2_W-1:0] md2);
        drain_swipes();
        write_reg(REG_TIME_LIMIT, CFG_W'(lim));
        write_reg(REG_MIN_DIST2, CFG_W'(md2));
    endtask

    // ignored requests and basic gestures at the reset settings
    task automatic test_ignored_and_basic();
        send_event(CMD_TICK, 16'sd0, 16'sd0);            // tick while idle
        send_event(CMD_UNUSED, -16'sd1, -16'sd1);        // unused code
        send_event(CMD_RELEASE, 16'sd100, 16'sd100);     // release while idle
        // zero ticks, second press ignored
        send_event(CMD_PRESS, 16'sd0, 16'sd0);
        send_event(CMD_PRESS, 16'sd500, 16'sd500);
        send_event(CMD_RELEASE, 16'sd320, 16'sd0);
        // too short
        send_event(CMD_PRESS, 16'sd0, 16'sd0);
        send_event(CMD_TICK, 16'sd0, 16'sd0);
        send_event(CMD_RELEASE, 16'sd0, 16'sd100);
        // negative quotient truncates toward zero
        send_event(CMD_PRESS, 16'sd0, 16'sd0);
        repeat (3) send_event(CMD_TICK, 16'sd0, 16'sd0);
        send_event(CMD_RELEASE, -16'sd1000, 16'sd700);
    endtask

    // register extremes, output saturation and the distance boundary
    task automatic test_register_extremes();
        set_registers(16'hFFFF, '0);
        send_event(CMD_PRESS, -16'sd32768, 16'sd32767);
        send_event(CMD_RELEASE, 16'sd32767, -16'sd32768);
        send_event(CMD_PRESS, 16'sd5, 16'sd5);           // zero displacement
        send_event(CMD_RELEASE, 16'sd5, 16'sd5);

        set_registers(16'd1, 33'd100);
        send_event(CMD_PRESS, 16'sd10, -16'sd10);
        send_event(CMD_RELEASE, -16'sd200, 16'sd300);
        send_event(CMD_PRESS, 16'sd10, -16'sd10);        // one tick is too slow
        send_event(CMD_TICK, 16'sd0, 16'sd0);
        send_event(CMD_RELEASE, -16'sd200, 16'sd300);

        // zero time limit never swipes
        set_registers(16'd0, '0);
        send_event(CMD_PRESS, 16'sd0, 16'sd0);
        send_event(CMD_RELEASE, 16'sd4000, 16'sd4000);

        set_registers(16'd500, {MIN_D2_W{1'b1}});
        send_event(CMD_PRESS, -16'sd32768, -16'sd32768);
        send_event(CMD_RELEASE, 16'sd32767, 16'sd32767);

        // distance exactly at the minimum
        set_registers(16'd77, 33'd102400);
        send_event(CMD_PRESS, 16'sd1000, 16'sd1000);
        send_event(CMD_RELEASE, 16'sd1320, 16'sd1000);
    endtask

    // holds that end one tick below and exactly at the time limit
    task automatic test_long_hold();
        set_registers(LIMIT_RESET, MIN_D2_RESET);
        send_event(CMD_PRESS, 16'sd0, 16'sd0);
        repeat (int'(LIMIT_RESET) - 1) send_event(CMD_TICK, 16'sd0, 16'sd0);
        send_event(CMD_RELEASE, 16'sd4000, -16'sd4000);
        send_event(CMD_PRESS, 16'sd0, 16'sd0);
        repeat (int'(LIMIT_RESET)) send_event(CMD_TICK, 16'sd0, 16'sd0);
        send_event(CMD_RELEASE, 16'sd4000, -16'sd4000);
    endtask

    // result side stalls long enough for the input to back up
    task automatic test_output_backpressure();
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        set_registers(LIMIT_RESET, MIN_D2_RESET);
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        -> stall_sink;
        repeat (8) begin
            x = COORD_W'($urandom_range(0, 20000) - 10000);
            y = COORD_W'($urandom_range(0, 20000) - 10000);
            send_event(CMD_PRESS, x, y);
            send_event(CMD_RELEASE, x + 16'sd3000, y - 16'sd77);
        end
        drain_swipes();
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // one press/ticks/release sequence with random content
    task automatic random_gesture(output int sent);
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        int ticks;
        sx = COORD_W'($urandom);
        sy = COORD_W'($urandom);
        ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
        if ($urandom_range(0, 1)) begin
            ex = COORD_W'(sx + $urandom_range(0, 2047) - 1024);
            ey = COORD_W'(sy + $urandom_range(0, 2047) - 1024);
        end else begin
            ex = COORD_W'($urandom);
            ey = COORD_W'($urandom);
        end
        send_event(CMD_PRESS, sx, sy);
        for (int i = 0; i < ticks; i++) begin
            // stray press or unused code inside the gesture
            if ($urandom_range(0, 15) == 0)
                send_event(t_command'($urandom_range(1, 3) == 2 ? CMD_UNUSED : CMD_PRESS),
                           COORD_W'($urandom), COORD_W'($urandom));
            send_event(CMD_TICK, COORD_W'($urandom), COORD_W'($urandom));
        end
        send_event(CMD_RELEASE, ex, ey);
        sent = ticks + 2;
    endtask

    task automatic test_random_gestures();
        logic [LIMIT_W-1:0]  lim;
        logic [MIN_D2_W-1:0] md2;
        int sent;
        int phase_total;
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin lim = LIMIT_RESET; md2 = MIN_D2_RESET; end
                1: begin lim = 16'hFFFF; md2 = '0; end
                2: begin lim = 16'd1; md2 = 33'd1000; end
                3: begin
                    lim = LIMIT_W'($urandom_range(2, 40));
                    md2 = MIN_D2_W'($urandom_range(0, 2000000));
                end
                4: begin
                    lim = LIMIT_W'($urandom_range(1, 65535));
                    md2 = {1'($urandom_range(0, 1)), $urandom};
                end
                5: begin
                    lim = LIMIT_W'($urandom_range(2, 20));
                    md2 = MIN_D2_W'($urandom_range(0, 300000));
                end
                default: begin
                    lim = LIMIT_W'($urandom_range(1, 65535));
                    md2 = {MIN_D2_W{1'b1}};
                end
            endcase
            set_registers(lim, md2);
            phase_total = 0;
            while (phase_total < PHASE_REQUESTS) begin
                send_gaps = ($urandom_range(0, 3) != 0);
                sink_gaps = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 4) == 0) begin
                    send_event(t_command'($urandom_range(0, 3)),
                               COORD_W'($urandom), COORD_W'($urandom));
                end else begin
                    random_gesture(sent);
                    phase_total += sent;
                end
            end
        end
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // result side ready with random waits
    always @(negedge i_clk) begin
        if (swipes_taken != taken_seen) begin
            taken_seen = swipes_taken;
            sink_wait  = sink_gaps ? $urandom_range(0, 9) : 0;
        end
        if (sink_hold) begin
            swipe_bus.ready <= 1'b0;
        end else if (sink_wait > 0) begin
            swipe_bus.ready <= 1'b0;
            sink_wait--;
        end else begin
            swipe_bus.ready <= 1'b1;
        end
    end

    // long stall of the result side
    always begin
        @(stall_sink);
        @(negedge i_clk);
        sink_hold <= 1'b1;
        repeat (SINK_HOLD_CYCLES) @(negedge i_clk);
        sink_hold <= 1'b0;
    end

    // compare each swipe with the oldest prediction
    always @(posedge i_clk) begin : check_swipes
        t_swipe want;
        if (i_rst_n && swipe_bus.valid && swipe_bus.ready) begin
            swipes_taken <= swipes_taken + 1;
            if (pending_swipes.size() == 0) begin
                flag_failure($sformatf("unexpected swipe dx=%0d dy=%0d",
                                       swipe_bus.swipe_dx, swipe_bus.swipe_dy));
            end else begin
                want = pending_swipes.pop_front();
                if (want.dx !== swipe_bus.swipe_dx || want.dy !== swipe_bus.swipe_dy)
                    flag_failure($sformatf("swipe expected dx=%0d dy=%0d, got dx=%0d dy=%0d",
                                           want.dx, want.dy,
                                           swipe_bus.swipe_dx, swipe_bus.swipe_dy));
            end
        end
    end

    // stop a run in which nothing moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (evt_bus.valid && evt_bus.ready) ||
            (swipe_bus.valid && swipe_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("swipe_gesture_detector_top: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // test sequence
    initial begin
        i_rst_n         = 1'b0;
        evt_bus.valid   = 1'b0;
        evt_bus.command = CMD_TICK;
        evt_bus.x_pos   = '0;
        evt_bus.y_pos   = '0;
        cfg_bus.valid   = 1'b0;
        cfg_bus.index   = REG_TIME_LIMIT;
        cfg_bus.data    = '0;
        swipe_bus.ready = 1'b0;
        touch_down      = 1'b0;
        origin_x        = '0;
        origin_y        = '0;
        held_ticks      = '0;
        time_limit      = LIMIT_RESET;
        min_dist2       = MIN_D2_RESET;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_ignored_and_basic();
        test_register_extremes();
        test_long_hold();
        test_output_backpressure();
        test_random_gestures();
        drain_swipes();

        if (mismatches == 0 && pending_swipes.size() == 0)
            $display("swipe_gesture_detector_top: match");
        else
            $display("swipe_gesture_detector_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

[swipe_gesture_detector_top.f]
rtl/sgd_pkg.sv
rtl/sgd_if.sv
rtl/swipe_gesture_detector_top.sv
tb/sv/tb.sv
